>>> rtl/svm_pkg.sv
// svm_pkg: shared types and constants of the stack virtual machine step unit
// opcode, command, status and state codes, controller/datapath command and status structs
// no dependencies
package svm_pkg;

    localparam int PTR_W       = 17;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 14;
    localparam int CFG_W       = 17;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [PTR_W-1:0] PC_RESET = 17'd0;
    localparam logic [PTR_W-1:0] SP_RESET = 17'd65536;

    typedef enum logic {
        CFG_START_ADDR = 1'b0,
        CFG_STACK_TOP  = 1'b1
    } cfg_idx_e;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_NONE  = 2'd3
    } item_cmd_e;

    typedef enum logic [2:0] {
        RS_RUN   = 3'd0,
        RS_EXIT  = 3'd1,
        RS_BADOP = 3'd2,
        RS_DIV0  = 3'd3,
        RS_ADDR  = 3'd4
    } run_status_e;

    typedef enum logic [5:0] {
        OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_CALL = 6'd3,
        OP_JZ   = 6'd4,  OP_JNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
        OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_LC   = 6'd10, OP_SI   = 6'd11,
        OP_SC   = 6'd12, OP_PUSH = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
        OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
        OP_GT   = 6'd20, OP_LE   = 6'd21, OP_GE   = 6'd22, OP_SHL  = 6'd23,
        OP_SHR  = 6'd24, OP_ADD  = 6'd25, OP_SUB  = 6'd26, OP_MUL  = 6'd27,
        OP_DIV  = 6'd28, OP_MOD  = 6'd29, OP_EXIT = 6'd37, OP_BAD  = 6'd63
    } op_e;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_RDCAP, ST_OPCAP, ST_DECODE, ST_IMMCAP, ST_EXEC,
        ST_TCAP, ST_TOP, ST_SCWR, ST_LOADCAP, ST_LEV_T, ST_LEV_R, ST_LEV_CHK,
        ST_DIV, ST_RESP
    } state_e;

    typedef enum logic [3:0] {
        MA_IDX, MA_PC, MA_PC4, MA_SP, MA_SPM4, MA_FP, MA_FP4, MA_ACC, MA_T
    } mem_addr_e;

    typedef enum logic [2:0] {
        WD_ITEM, WD_PC_NEXT, WD_FP, WD_ACC, WD_BYTE
    } wdata_e;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_OP, CAP_IMM, CAP_T, CAP_R, CAP_RD
    } cap_e;

    typedef struct packed {
        logic        latch;
        logic        mem_re;
        logic        mem_we;
        mem_addr_e   addr;
        wdata_e      wd;
        cap_e        cap;
        logic        commit;
        logic        fault;
        run_status_e code;
        logic        div_start;
        logic        load_out;
    } dp_cmd_t;

    typedef struct packed {
        item_cmd_e cmd;
        op_e       op;
        logic      has_imm;
        logic      running;
        logic      idx_ok;
        logic      pc_ok;
        logic      pc4_ok;
        logic      sp_ok;
        logic      spm4_ok;
        logic      imm_ok;
        logic      fp_ok;
        logic      fp4_ok;
        logic      acc_ok;
        logic      acc_byte_ok;
        logic      t_ok;
        logic      t_byte_ok;
        logic      t_fp_ok;
        logic      r_ok;
        logic      ent_ok;
        logic      adj_ok;
        logic      acc_zero;
        logic      jump_taken;
        logic      div_done;
    } dp_stat_t;

    function automatic op_e decode_op(input logic [WORD_W-1:0] w);
        op_e o;
        if (w <= 32'd29 || w == 32'd37) begin
            o = op_e'(w[5:0]);
        end else begin
            o = OP_BAD;
        end
        return o;
    endfunction

endpackage

>>> rtl/svm_div.sv
// svm_div: signed 32-bit divider, one quotient bit per cycle (restoring)
// truncating quotient and remainder; depends on svm_pkg
module svm_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [svm_pkg::WORD_W-1:0]      dividend,
    input  logic [svm_pkg::WORD_W-1:0]      divisor,
    output logic                            done,
    output logic [svm_pkg::WORD_W-1:0]      quotient,
    output logic [svm_pkg::WORD_W-1:0]      remainder
);

    logic [svm_pkg::WORD_W-1:0]    rem_reg, quo_reg, den_reg;
    logic [svm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg, done_reg, neg_q_reg, neg_r_reg;
    logic [svm_pkg::WORD_W:0]      shifted, diff;

    assign shifted = {rem_reg, quo_reg[svm_pkg::WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= dividend[svm_pkg::WORD_W-1] ? -dividend : dividend;
            den_reg   <= divisor[svm_pkg::WORD_W-1] ? -divisor : divisor;
            neg_q_reg <= dividend[svm_pkg::WORD_W-1] ^ divisor[svm_pkg::WORD_W-1];
            neg_r_reg <= dividend[svm_pkg::WORD_W-1];
        end else if (busy_reg) begin
            if (!diff[svm_pkg::WORD_W]) begin
                rem_reg <= diff[svm_pkg::WORD_W-1:0];
                quo_reg <= {quo_reg[svm_pkg::WORD_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[svm_pkg::WORD_W-1:0];
                quo_reg <= {quo_reg[svm_pkg::WORD_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == svm_pkg::DIV_CNT_W'(svm_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? -quo_reg : quo_reg;
    assign remainder = neg_r_reg ? -rem_reg : rem_reg;

endmodule

>>> rtl/svm_dp.sv
// svm_dp: datapath of the stack machine: word memory, machine registers, alu, checks
// driven by svm_ctrl commands; depends on svm_pkg and svm_div
module svm_dp #(
    parameter int MEM_WORDS = 16384
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [svm_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic [1:0]                          s_cmd,
    input  logic [svm_pkg::IDX_W-1:0]           s_word_index,
    input  logic signed [svm_pkg::WORD_W-1:0]   s_write_value,
    input  svm_pkg::dp_cmd_t                    cmd,
    output svm_pkg::dp_stat_t                   stat,
    output logic signed [svm_pkg::WORD_W-1:0]   m_read_value,
    output logic signed [svm_pkg::WORD_W-1:0]   m_accumulator_out,
    output logic [svm_pkg::PTR_W-1:0]           m_program_counter_out,
    output logic [svm_pkg::PTR_W-1:0]           m_stack_pointer_out,
    output logic [2:0]                          m_run_status,
    output logic signed [svm_pkg::WORD_W-1:0]   m_exit_value
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [svm_pkg::PTR_W-1:0]  MB17 = svm_pkg::PTR_W'(4 * MEM_WORDS);
    localparam logic [svm_pkg::WORD_W-1:0] MB32 = svm_pkg::WORD_W'(4 * MEM_WORDS);
    localparam logic signed [35:0]         MB36 = 36'(4 * MEM_WORDS);

    logic [svm_pkg::WORD_W-1:0] mem [MEM_WORDS];

    logic [svm_pkg::WORD_W-1:0] acc_reg, acc_next, exit_reg;
    logic [svm_pkg::PTR_W-1:0]  pc_reg, pc_next, sp_reg, sp_next, fp_reg, fp_next;
    svm_pkg::run_status_e       status_reg;
    svm_pkg::item_cmd_e         cmd_reg;
    logic [svm_pkg::IDX_W-1:0]  idx_reg;
    logic [svm_pkg::WORD_W-1:0] val_reg, op_reg, imm_reg, t_reg, r_reg, rdata_reg, rd_reg;

    svm_pkg::op_e               op;
    logic                       has_imm, idx_ok, taken;
    logic [svm_pkg::PTR_W-1:0]  spm4, fp4, pc4, pc_step;
    logic signed [35:0]         imm4, ent_n, adj_n;
    logic [svm_pkg::WORD_W-1:0] byte_addr, wdata, alu_res, lc_word, lc_val, sc_word;
    logic [svm_pkg::WORD_W-1:0] div_q, div_r;
    logic [AW-1:0]              maddr;
    logic                       div_done;

    assign op      = svm_pkg::decode_op(op_reg);
    assign has_imm = (op <= svm_pkg::OP_ADJ);
    assign idx_ok  = ({2'b00, idx_reg} < 16'(MEM_WORDS));
    assign spm4    = sp_reg - 17'd4;
    assign fp4     = fp_reg + 17'd4;
    assign pc4     = pc_reg + 17'd4;
    assign pc_step = pc_reg + (has_imm ? 17'd8 : 17'd4);
    assign imm4    = {{2{imm_reg[31]}}, imm_reg, 2'b00};
    assign ent_n   = $signed({19'b0, spm4}) - imm4;
    assign adj_n   = $signed({19'b0, sp_reg}) + imm4;
    assign taken   = ((acc_reg == '0) == (op == svm_pkg::OP_JZ));

    always_comb begin
        stat             = '0;
        stat.cmd         = cmd_reg;
        stat.op          = op;
        stat.has_imm     = has_imm;
        stat.running     = (status_reg == svm_pkg::RS_RUN);
        stat.idx_ok      = idx_ok;
        stat.pc_ok       = (pc_reg < MB17) && (pc_reg[1:0] == 2'b00);
        stat.pc4_ok      = (pc4 < MB17) && (pc4[1:0] == 2'b00);
        stat.sp_ok       = (sp_reg < MB17) && (sp_reg[1:0] == 2'b00);
        stat.spm4_ok     = (spm4 < MB17) && (spm4[1:0] == 2'b00);
        stat.imm_ok      = (imm_reg < MB32) && (imm_reg[1:0] == 2'b00);
        stat.fp_ok       = (fp_reg < MB17) && (fp_reg[1:0] == 2'b00);
        stat.fp4_ok      = (fp4 < MB17) && (fp4[1:0] == 2'b00);
        stat.acc_ok      = (acc_reg < MB32) && (acc_reg[1:0] == 2'b00);
        stat.acc_byte_ok = (acc_reg < MB32);
        stat.t_ok        = (t_reg < MB32) && (t_reg[1:0] == 2'b00);
        stat.t_byte_ok   = (t_reg < MB32);
        stat.t_fp_ok     = (t_reg <= MB32);
        stat.r_ok        = (r_reg < MB32) && (r_reg[1:0] == 2'b00);
        stat.ent_ok      = !ent_n[35] && (ent_n <= MB36);
        stat.adj_ok      = !adj_n[35] && (adj_n <= MB36);
        stat.acc_zero    = (acc_reg == '0);
        stat.jump_taken  = taken;
        stat.div_done    = div_done;
    end

    // memory address and write data
    always_comb begin
        case (cmd.addr)
            svm_pkg::MA_PC:   byte_addr = {15'b0, pc_reg};
            svm_pkg::MA_PC4:  byte_addr = {15'b0, pc4};
            svm_pkg::MA_SP:   byte_addr = {15'b0, sp_reg};
            svm_pkg::MA_SPM4: byte_addr = {15'b0, spm4};
            svm_pkg::MA_FP:   byte_addr = {15'b0, fp_reg};
            svm_pkg::MA_FP4:  byte_addr = {15'b0, fp4};
            svm_pkg::MA_ACC:  byte_addr = acc_reg;
            svm_pkg::MA_T:    byte_addr = t_reg;
            default:          byte_addr = '0;
        endcase
        if (cmd.addr == svm_pkg::MA_IDX) begin
            maddr = idx_reg[AW-1:0];
        end else begin
            maddr = byte_addr[AW+1:2];
        end
    end

    always_comb begin
        case (t_reg[1:0])
            2'd0:    sc_word = {rdata_reg[31:8], acc_reg[7:0]};
            2'd1:    sc_word = {rdata_reg[31:16], acc_reg[7:0], rdata_reg[7:0]};
            2'd2:    sc_word = {rdata_reg[31:24], acc_reg[7:0], rdata_reg[15:0]};
            default: sc_word = {acc_reg[7:0], rdata_reg[23:0]};
        endcase
        case (cmd.wd)
            svm_pkg::WD_ITEM:    wdata = val_reg;
            svm_pkg::WD_PC_NEXT: wdata = {15'b0, pc_step};
            svm_pkg::WD_FP:      wdata = {15'b0, fp_reg};
            svm_pkg::WD_ACC:     wdata = acc_reg;
            svm_pkg::WD_BYTE:    wdata = sc_word;
            default:             wdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[maddr] <= wdata;
        end
        if (cmd.mem_re) begin
            rdata_reg <= mem[maddr];
        end
    end

    svm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (t_reg),
        .divisor   (acc_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // alu with popped stack top
    always_comb begin
        case (op)
            svm_pkg::OP_OR:  alu_res = t_reg | acc_reg;
            svm_pkg::OP_XOR: alu_res = t_reg ^ acc_reg;
            svm_pkg::OP_AND: alu_res = t_reg & acc_reg;
            svm_pkg::OP_EQ:  alu_res = {31'b0, t_reg == acc_reg};
            svm_pkg::OP_NE:  alu_res = {31'b0, t_reg != acc_reg};
            svm_pkg::OP_LT:  alu_res = {31'b0, $signed(t_reg) < $signed(acc_reg)};
            svm_pkg::OP_GT:  alu_res = {31'b0, $signed(t_reg) > $signed(acc_reg)};
            svm_pkg::OP_LE:  alu_res = {31'b0, $signed(t_reg) <= $signed(acc_reg)};
            svm_pkg::OP_GE:  alu_res = {31'b0, $signed(t_reg) >= $signed(acc_reg)};
            svm_pkg::OP_SHL: alu_res = (acc_reg >= 32'd32) ? '0 : (t_reg << acc_reg[4:0]);
            svm_pkg::OP_SHR: alu_res = (acc_reg >= 32'd32) ? {32{t_reg[31]}}
                                       : 32'($signed(t_reg) >>> acc_reg[4:0]);
            svm_pkg::OP_ADD: alu_res = t_reg + acc_reg;
            svm_pkg::OP_SUB: alu_res = t_reg - acc_reg;
            svm_pkg::OP_MUL: alu_res = t_reg * acc_reg;
            svm_pkg::OP_DIV: alu_res = div_q;
            svm_pkg::OP_MOD: alu_res = div_r;
            default:         alu_res = '0;
        endcase
    end

    assign lc_word = rdata_reg >> {acc_reg[1:0], 3'b000};
    assign lc_val  = {{24{lc_word[7]}}, lc_word[7:0]};

    // committed machine state of the instruction
    always_comb begin
        acc_next = acc_reg;
        pc_next  = pc_step;
        sp_next  = sp_reg;
        fp_next  = fp_reg;
        case (op)
            svm_pkg::OP_LEA:  acc_next = {15'b0, fp_reg} + {imm_reg[29:0], 2'b00};
            svm_pkg::OP_IMM:  acc_next = imm_reg;
            svm_pkg::OP_JMP:  pc_next  = imm_reg[svm_pkg::PTR_W-1:0];
            svm_pkg::OP_CALL: begin
                pc_next = imm_reg[svm_pkg::PTR_W-1:0];
                sp_next = spm4;
            end
            svm_pkg::OP_JZ, svm_pkg::OP_JNZ: begin
                if (taken) begin
                    pc_next = imm_reg[svm_pkg::PTR_W-1:0];
                end
            end
            svm_pkg::OP_ENT: begin
                fp_next = spm4;
                sp_next = ent_n[svm_pkg::PTR_W-1:0];
            end
            svm_pkg::OP_ADJ:  sp_next = adj_n[svm_pkg::PTR_W-1:0];
            svm_pkg::OP_LEV: begin
                sp_next = fp_reg + 17'd8;
                fp_next = t_reg[svm_pkg::PTR_W-1:0];
                pc_next = r_reg[svm_pkg::PTR_W-1:0];
            end
            svm_pkg::OP_LI:   acc_next = rdata_reg;
            svm_pkg::OP_LC:   acc_next = lc_val;
            svm_pkg::OP_SI:   sp_next  = sp_reg + 17'd4;
            svm_pkg::OP_SC: begin
                sp_next  = sp_reg + 17'd4;
                acc_next = {{24{acc_reg[7]}}, acc_reg[7:0]};
            end
            svm_pkg::OP_PUSH: sp_next  = spm4;
            svm_pkg::OP_EXIT: ;
            default: begin
                sp_next  = sp_reg + 17'd4;
                acc_next = alu_res;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            pc_reg     <= svm_pkg::PC_RESET;
            sp_reg     <= svm_pkg::SP_RESET;
            fp_reg     <= svm_pkg::SP_RESET;
            status_reg <= svm_pkg::RS_RUN;
            cmd_reg    <= svm_pkg::CMD_NONE;
        end else begin
            if (cfg_wr_en) begin
                if (svm_pkg::cfg_idx_e'(cfg_index) == svm_pkg::CFG_START_ADDR) begin
                    pc_reg <= {1'b0, cfg_wdata[15:0]};
                end else begin
                    sp_reg <= cfg_wdata;
                    fp_reg <= cfg_wdata;
                end
            end
            if (cmd.latch) begin
                cmd_reg <= svm_pkg::item_cmd_e'(s_cmd);
            end
            if (cmd.fault) begin
                status_reg <= cmd.code;
            end
            if (cmd.commit) begin
                acc_reg <= acc_next;
                pc_reg  <= pc_next;
                sp_reg  <= sp_next;
                fp_reg  <= fp_next;
                if (op == svm_pkg::OP_EXIT) begin
                    status_reg <= svm_pkg::RS_EXIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            idx_reg <= s_word_index;
            val_reg <= s_write_value;
            rd_reg  <= '0;
        end
        case (cmd.cap)
            svm_pkg::CAP_OP:  op_reg  <= rdata_reg;
            svm_pkg::CAP_IMM: imm_reg <= rdata_reg;
            svm_pkg::CAP_T:   t_reg   <= rdata_reg;
            svm_pkg::CAP_R:   r_reg   <= rdata_reg;
            svm_pkg::CAP_RD:  rd_reg  <= idx_ok ? rdata_reg : '0;
            default: ;
        endcase
        if (cmd.commit && op == svm_pkg::OP_EXIT) begin
            exit_reg <= t_reg;
        end
        if (cmd.load_out) begin
            m_read_value          <= rd_reg;
            m_accumulator_out     <= acc_reg;
            m_program_counter_out <= pc_reg;
            m_stack_pointer_out   <= sp_reg;
            m_run_status          <= status_reg;
            m_exit_value          <= (status_reg == svm_pkg::RS_EXIT) ? exit_reg : '0;
        end
    end

endmodule

>>> rtl/svm_ctrl.sv
// svm_ctrl: sequencing state machine of the stack machine step unit
// issues datapath commands, owns the handshakes; depends on svm_pkg
module svm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  svm_pkg::dp_stat_t  stat,
    output svm_pkg::dp_cmd_t   cmd
);

    svm_pkg::state_e state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            exec_ok, top_ok, out_free;

    assign out_free = !m_valid_reg || m_ready;

    // checks of the instruction at the execute and stack top steps
    always_comb begin
        case (stat.op)
            svm_pkg::OP_LEA, svm_pkg::OP_IMM:  exec_ok = 1'b1;
            svm_pkg::OP_JMP:                   exec_ok = stat.imm_ok;
            svm_pkg::OP_CALL:                  exec_ok = stat.spm4_ok && stat.imm_ok;
            svm_pkg::OP_JZ, svm_pkg::OP_JNZ:   exec_ok = !stat.jump_taken || stat.imm_ok;
            svm_pkg::OP_ENT:                   exec_ok = stat.spm4_ok && stat.ent_ok;
            svm_pkg::OP_ADJ:                   exec_ok = stat.adj_ok;
            svm_pkg::OP_LEV:                   exec_ok = stat.fp_ok && stat.fp4_ok;
            svm_pkg::OP_LI:                    exec_ok = stat.acc_ok;
            svm_pkg::OP_LC:                    exec_ok = stat.acc_byte_ok;
            svm_pkg::OP_PUSH:                  exec_ok = stat.spm4_ok;
            svm_pkg::OP_BAD:                   exec_ok = 1'b0;
            default:                           exec_ok = stat.sp_ok;
        endcase
        case (stat.op)
            svm_pkg::OP_SI:                    top_ok = stat.t_ok;
            svm_pkg::OP_SC:                    top_ok = stat.t_byte_ok;
            svm_pkg::OP_DIV, svm_pkg::OP_MOD:  top_ok = !stat.acc_zero;
            default:                           top_ok = 1'b1;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            svm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = svm_pkg::ST_DISPATCH;
                end
            end
            svm_pkg::ST_DISPATCH: begin
                state_next = svm_pkg::ST_RESP;
                if (stat.cmd == svm_pkg::CMD_READ) begin
                    state_next = svm_pkg::ST_RDCAP;
                end else if (stat.cmd == svm_pkg::CMD_EXEC && stat.running && stat.pc_ok) begin
                    state_next = svm_pkg::ST_OPCAP;
                end
            end
            svm_pkg::ST_RDCAP:  state_next = svm_pkg::ST_RESP;
            svm_pkg::ST_OPCAP:  state_next = svm_pkg::ST_DECODE;
            svm_pkg::ST_DECODE: begin
                if (!stat.has_imm) begin
                    state_next = svm_pkg::ST_EXEC;
                end else if (stat.pc4_ok) begin
                    state_next = svm_pkg::ST_IMMCAP;
                end else begin
                    state_next = svm_pkg::ST_RESP;
                end
            end
            svm_pkg::ST_IMMCAP: state_next = svm_pkg::ST_EXEC;
            svm_pkg::ST_EXEC: begin
                state_next = svm_pkg::ST_RESP;
                if (exec_ok) begin
                    case (stat.op)
                        svm_pkg::OP_LEV:                 state_next = svm_pkg::ST_LEV_T;
                        svm_pkg::OP_LI, svm_pkg::OP_LC:  state_next = svm_pkg::ST_LOADCAP;
                        svm_pkg::OP_SI, svm_pkg::OP_SC,
                        svm_pkg::OP_EXIT:                state_next = svm_pkg::ST_TCAP;
                        default: begin
                            if (stat.op >= svm_pkg::OP_OR && stat.op <= svm_pkg::OP_MOD) begin
                                state_next = svm_pkg::ST_TCAP;
                            end
                        end
                    endcase
                end
            end
            svm_pkg::ST_TCAP:   state_next = svm_pkg::ST_TOP;
            svm_pkg::ST_TOP: begin
                state_next = svm_pkg::ST_RESP;
                if (top_ok && (stat.op == svm_pkg::OP_DIV || stat.op == svm_pkg::OP_MOD)) begin
                    state_next = svm_pkg::ST_DIV;
                end else if (top_ok && stat.op == svm_pkg::OP_SC) begin
                    state_next = svm_pkg::ST_SCWR;
                end
            end
            svm_pkg::ST_SCWR:    state_next = svm_pkg::ST_RESP;
            svm_pkg::ST_LOADCAP: state_next = svm_pkg::ST_RESP;
            svm_pkg::ST_LEV_T:   state_next = svm_pkg::ST_LEV_R;
            svm_pkg::ST_LEV_R:   state_next = svm_pkg::ST_LEV_CHK;
            svm_pkg::ST_LEV_CHK: state_next = svm_pkg::ST_RESP;
            svm_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = svm_pkg::ST_RESP;
                end
            end
            svm_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = svm_pkg::ST_IDLE;
                end
            end
            default: state_next = svm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.addr = svm_pkg::MA_IDX;
        cmd.wd   = svm_pkg::WD_ITEM;
        cmd.cap  = svm_pkg::CAP_NONE;
        cmd.code = svm_pkg::RS_ADDR;
        case (state_reg)
            svm_pkg::ST_IDLE: cmd.latch = s_valid;
            svm_pkg::ST_DISPATCH: begin
                case (stat.cmd)
                    svm_pkg::CMD_WRITE: cmd.mem_we = stat.idx_ok;
                    svm_pkg::CMD_READ:  cmd.mem_re = 1'b1;
                    svm_pkg::CMD_EXEC: begin
                        if (stat.running) begin
                            cmd.addr   = svm_pkg::MA_PC;
                            cmd.mem_re = stat.pc_ok;
                            cmd.fault  = !stat.pc_ok;
                        end
                    end
                    default: ;
                endcase
            end
            svm_pkg::ST_RDCAP:  cmd.cap = svm_pkg::CAP_RD;
            svm_pkg::ST_OPCAP:  cmd.cap = svm_pkg::CAP_OP;
            svm_pkg::ST_DECODE: begin
                if (stat.has_imm) begin
                    cmd.addr   = svm_pkg::MA_PC4;
                    cmd.mem_re = stat.pc4_ok;
                    cmd.fault  = !stat.pc4_ok;
                end
            end
            svm_pkg::ST_IMMCAP: cmd.cap = svm_pkg::CAP_IMM;
            svm_pkg::ST_EXEC: begin
                if (!exec_ok) begin
                    cmd.fault = 1'b1;
                    cmd.code  = (stat.op == svm_pkg::OP_BAD) ? svm_pkg::RS_BADOP
                                                             : svm_pkg::RS_ADDR;
                end else begin
                    case (stat.op)
                        svm_pkg::OP_LEV: begin
                            cmd.addr   = svm_pkg::MA_FP;
                            cmd.mem_re = 1'b1;
                        end
                        svm_pkg::OP_LI, svm_pkg::OP_LC: begin
                            cmd.addr   = svm_pkg::MA_ACC;
                            cmd.mem_re = 1'b1;
                        end
                        svm_pkg::OP_CALL: begin
                            cmd.addr   = svm_pkg::MA_SPM4;
                            cmd.wd     = svm_pkg::WD_PC_NEXT;
                            cmd.mem_we = 1'b1;
                            cmd.commit = 1'b1;
                        end
                        svm_pkg::OP_ENT: begin
                            cmd.addr   = svm_pkg::MA_SPM4;
                            cmd.wd     = svm_pkg::WD_FP;
                            cmd.mem_we = 1'b1;
                            cmd.commit = 1'b1;
                        end
                        svm_pkg::OP_PUSH: begin
                            cmd.addr   = svm_pkg::MA_SPM4;
                            cmd.wd     = svm_pkg::WD_ACC;
                            cmd.mem_we = 1'b1;
                            cmd.commit = 1'b1;
                        end
                        svm_pkg::OP_LEA, svm_pkg::OP_IMM, svm_pkg::OP_JMP, svm_pkg::OP_JZ,
                        svm_pkg::OP_JNZ, svm_pkg::OP_ADJ: cmd.commit = 1'b1;
                        default: begin
                            cmd.addr   = svm_pkg::MA_SP;
                            cmd.mem_re = 1'b1;
                        end
                    endcase
                end
            end
            svm_pkg::ST_TCAP: cmd.cap = svm_pkg::CAP_T;
            svm_pkg::ST_TOP: begin
                if (!top_ok) begin
                    cmd.fault = 1'b1;
                    cmd.code  = (stat.op == svm_pkg::OP_SI || stat.op == svm_pkg::OP_SC)
                                ? svm_pkg::RS_ADDR : svm_pkg::RS_DIV0;
                end else begin
                    case (stat.op)
                        svm_pkg::OP_DIV, svm_pkg::OP_MOD: cmd.div_start = 1'b1;
                        svm_pkg::OP_SC: begin
                            cmd.addr   = svm_pkg::MA_T;
                            cmd.mem_re = 1'b1;
                        end
                        svm_pkg::OP_SI: begin
                            cmd.addr   = svm_pkg::MA_T;
                            cmd.wd     = svm_pkg::WD_ACC;
                            cmd.mem_we = 1'b1;
                            cmd.commit = 1'b1;
                        end
                        default: cmd.commit = 1'b1;
                    endcase
                end
            end
            svm_pkg::ST_SCWR: begin
                cmd.addr   = svm_pkg::MA_T;
                cmd.wd     = svm_pkg::WD_BYTE;
                cmd.mem_we = 1'b1;
                cmd.commit = 1'b1;
            end
            svm_pkg::ST_LOADCAP: cmd.commit = 1'b1;
            svm_pkg::ST_LEV_T: begin
                cmd.cap    = svm_pkg::CAP_T;
                cmd.addr   = svm_pkg::MA_FP4;
                cmd.mem_re = 1'b1;
            end
            svm_pkg::ST_LEV_R: cmd.cap = svm_pkg::CAP_R;
            svm_pkg::ST_LEV_CHK: begin
                cmd.commit = stat.t_fp_ok && stat.r_ok;
                cmd.fault  = !(stat.t_fp_ok && stat.r_ok);
            end
            svm_pkg::ST_DIV:  cmd.commit   = stat.div_done;
            svm_pkg::ST_RESP: cmd.load_out = out_free;
            default: ;
        endcase
    end

    assign m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= svm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == svm_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> rtl/stack_vm_instruction_step_unit.sv
// stack_vm_instruction_step_unit: one item at a time; writes, reads and instructions use
// the single memory port, and DIV/MOD also use the 32-step divider
// result sits in an output register, so the next item is taken while it waits
// reset clears control state, accumulator and status; pc 0, sp and fp 65536;
// memory contents are undefined until written
module stack_vm_instruction_step_unit #(
    parameter int MEM_WORDS = 16384
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [svm_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic [svm_pkg::IDX_W-1:0]           s_word_index,
    input  logic signed [svm_pkg::WORD_W-1:0]   s_write_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [svm_pkg::WORD_W-1:0]   m_read_value,
    output logic signed [svm_pkg::WORD_W-1:0]   m_accumulator_out,
    output logic [svm_pkg::PTR_W-1:0]           m_program_counter_out,
    output logic [svm_pkg::PTR_W-1:0]           m_stack_pointer_out,
    output logic [2:0]                          m_run_status,
    output logic signed [svm_pkg::WORD_W-1:0]   m_exit_value
);

    svm_pkg::dp_cmd_t  cmd;
    svm_pkg::dp_stat_t stat;

    svm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    svm_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_cmd                 (s_cmd),
        .s_word_index          (s_word_index),
        .s_write_value         (s_write_value),
        .cmd                   (cmd),
        .stat                  (stat),
        .m_read_value          (m_read_value),
        .m_accumulator_out     (m_accumulator_out),
        .m_program_counter_out (m_program_counter_out),
        .m_stack_pointer_out   (m_stack_pointer_out),
        .m_run_status          (m_run_status),
        .m_exit_value          (m_exit_value)
    );

endmodule

>>> rtl/svm_chk.sv
// svm_chk: port-level checks of the stack machine step unit, bound to the top level
// depends on svm_pkg and stack_vm_instruction_step_unit
module svm_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [svm_pkg::WORD_W-1:0]        m_accumulator_out,
    input logic [svm_pkg::PTR_W-1:0]         m_program_counter_out,
    input logic [2:0]                        m_run_status,
    input logic [svm_pkg::WORD_W-1:0]        m_exit_value
);

    // a waiting item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_accumulator_out)
            && $stable(m_program_counter_out) && $stable(m_run_status))
        else $error("svm_chk: result changed while stalled");

    // one item in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("svm_chk: item taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_status != svm_pkg::RS_EXIT |-> m_exit_value == '0)
        else $error("svm_chk: exit value without exit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_run_status <= svm_pkg::RS_ADDR)
        else $error("svm_chk: bad run status");

endmodule

bind stack_vm_instruction_step_unit svm_chk u_svm_chk (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_valid               (s_valid),
    .s_ready               (s_ready),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_accumulator_out     (m_accumulator_out),
    .m_program_counter_out (m_program_counter_out),
    .m_run_status          (m_run_status),
    .m_exit_value          (m_exit_value)
);

>>> tb/svm_result_checker.sv
// svm_result_checker: watches the config port and both item channels of the vm step unit,
// keeps its own copy of the machine, predicts every result and compares all its fields at once
// depends on svm_pkg
module svm_result_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [16:0]           cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [13:0]           s_word_index,
    input  logic [31:0]           s_write_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [31:0]           m_read_value,
    input  logic [31:0]           m_accumulator_out,
    input  logic [16:0]           m_program_counter_out,
    input  logic [16:0]           m_stack_pointer_out,
    input  logic [2:0]            m_run_status,
    input  logic [31:0]           m_exit_value,
    output int                    mismatch_count,
    output int                    outstanding,
    output logic [31:0]           vm_pc,
    output logic [31:0]           vm_sp,
    output logic [31:0]           vm_fp,
    output logic [31:0]           vm_acc
);
    timeunit 1ns;
    timeprecision 1ps;
    import svm_pkg::*;

    localparam longint MEM_BYTES = 65536;

    typedef struct packed {
        logic [31:0] rd;
        logic [31:0] acc;
        logic [16:0] pc;
        logic [16:0] sp;
        logic [2:0]  st;
        logic [31:0] ex;
    } vm_result_t;

    logic [31:0]  vm_mem [0:16383];
    logic [31:0]  vm_exit;
    logic [31:0]  vm_start;
    logic [31:0]  vm_stack_top;
    run_status_e  vm_status;
    vm_result_t   expected_results [$];

    function automatic bit word_ok(logic [31:0] a);
        return a < MEM_BYTES && a[1:0] == 2'b00;
    endfunction

    function automatic logic [31:0] mem_word(logic [31:0] a);
        return vm_mem[a[15:2]];
    endfunction

    function automatic logic [31:0] sext8(logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic run_status_e vm_execute();
        logic [31:0] p, s, f, a, op, imm, t, r, w;
        longint n;
        p = vm_pc;
        s = vm_sp;
        f = vm_fp;
        a = vm_acc;
        imm = '0;
        r = '0;
        if (!word_ok(p)) return RS_ADDR;
        op = mem_word(p);
        if (op <= 32'd7) begin
            if (!word_ok(p + 32'd4)) return RS_ADDR;
            imm = mem_word(p + 32'd4);
            p = p + 32'd8;
        end else begin
            p = p + 32'd4;
        end
        if (op >= 32'd14 && op <= 32'd29) begin
            if (!word_ok(s)) return RS_ADDR;
            t = mem_word(s);
            s = s + 32'd4;
            case (op)
                OP_OR:  r = t | a;
                OP_XOR: r = t ^ a;
                OP_AND: r = t & a;
                OP_EQ:  r = {31'd0, t == a};
                OP_NE:  r = {31'd0, t != a};
                OP_LT:  r = {31'd0, $signed(t) < $signed(a)};
                OP_GT:  r = {31'd0, $signed(t) > $signed(a)};
                OP_LE:  r = {31'd0, $signed(t) <= $signed(a)};
                OP_GE:  r = {31'd0, $signed(t) >= $signed(a)};
                OP_SHL: r = (a >= 32'd32) ? 32'd0 : t << a[4:0];
                OP_SHR: begin
                    r = $signed(t) >>> a[4:0];
                    if (a >= 32'd32) r = {32{t[31]}};
                end
                OP_ADD: r = t + a;
                OP_SUB: r = t - a;
                OP_MUL: r = t * a;
                default: begin
                    if (a == 32'd0) return RS_DIV0;
                    if (t == 32'h8000_0000 && a == 32'hFFFF_FFFF) begin
                        r = (op == OP_DIV) ? 32'h8000_0000 : 32'd0;
                    end else if (op == OP_DIV) begin
                        r = $signed(t) / $signed(a);
                    end else begin
                        r = $signed(t) % $signed(a);
                    end
                end
            endcase
            a = r;
        end else begin
            case (op)
                OP_LEA: a = f + (imm << 2);
                OP_IMM: a = imm;
                OP_JMP: begin
                    if (!word_ok(imm)) return RS_ADDR;
                    p = imm;
                end
                OP_CALL: begin
                    if (!word_ok(s - 32'd4) || !word_ok(imm)) return RS_ADDR;
                    s = s - 32'd4;
                    vm_mem[s[15:2]] = p;
                    p = imm;
                end
                OP_JZ, OP_JNZ: begin
                    if ((a == 32'd0) == (op == OP_JZ)) begin
                        if (!word_ok(imm)) return RS_ADDR;
                        p = imm;
                    end
                end
                OP_ENT: begin
                    if (!word_ok(s - 32'd4)) return RS_ADDR;
                    n = longint'(s - 32'd4) - 4 * longint'($signed(imm));
                    if (n < 0 || n > MEM_BYTES) return RS_ADDR;
                    t = s - 32'd4;
                    vm_mem[t[15:2]] = f;
                    f = t;
                    s = n[31:0];
                end
                OP_ADJ: begin
                    n = longint'(s) + 4 * longint'($signed(imm));
                    if (n < 0 || n > MEM_BYTES) return RS_ADDR;
                    s = n[31:0];
                end
                OP_LEV: begin
                    s = f;
                    if (!word_ok(s) || !word_ok(s + 32'd4)) return RS_ADDR;
                    t = mem_word(s);
                    r = mem_word(s + 32'd4);
                    if (t > MEM_BYTES || !word_ok(r)) return RS_ADDR;
                    f = t;
                    p = r;
                    s = s + 32'd8;
                end
                OP_LI: begin
                    if (!word_ok(a)) return RS_ADDR;
                    a = mem_word(a);
                end
                OP_LC: begin
                    if (a >= MEM_BYTES) return RS_ADDR;
                    w = mem_word(a) >> {a[1:0], 3'b000};
                    a = sext8(w[7:0]);
                end
                OP_SI: begin
                    if (!word_ok(s)) return RS_ADDR;
                    t = mem_word(s);
                    if (!word_ok(t)) return RS_ADDR;
                    s = s + 32'd4;
                    vm_mem[t[15:2]] = a;
                end
                OP_SC: begin
                    if (!word_ok(s)) return RS_ADDR;
                    t = mem_word(s);
                    if (t >= MEM_BYTES) return RS_ADDR;
                    s = s + 32'd4;
                    w = mem_word(t);
                    w[{t[1:0], 3'b000} +: 8] = a[7:0];
                    vm_mem[t[15:2]] = w;
                    a = sext8(a[7:0]);
                end
                OP_PUSH: begin
                    if (!word_ok(s - 32'd4)) return RS_ADDR;
                    s = s - 32'd4;
                    vm_mem[s[15:2]] = a;
                end
                OP_EXIT: begin
                    if (!word_ok(s)) return RS_ADDR;
                    vm_exit = mem_word(s);
                    vm_pc = p;
                    return RS_EXIT;
                end
                default: return RS_BADOP;
            endcase
        end
        vm_pc = p;
        vm_sp = s;
        vm_fp = f;
        vm_acc = a;
        return RS_RUN;
    endfunction

    always @(posedge aclk) begin
        vm_result_t exp_r, got_r;
        logic [31:0] rd;
        if (!aresetn) begin
            vm_start = 32'd0;
            vm_stack_top = 32'd65536;
            vm_pc = vm_start;
            vm_sp = vm_stack_top;
            vm_fp = vm_stack_top;
            vm_acc = 32'd0;
            vm_exit = 32'd0;
            vm_status = RS_RUN;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_r = '{m_read_value, m_accumulator_out, m_program_counter_out,
                          m_stack_pointer_out, m_run_status, m_exit_value};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: %p", got_r);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r !== exp_r) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch\n  expected %p\n  actual   %p",
                                     exp_r, got_r);
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_idx_e'(cfg_index) == CFG_START_ADDR) begin
                    vm_start = {16'd0, cfg_wdata[15:0]};
                    vm_pc = vm_start;
                end else begin
                    vm_stack_top = {15'd0, cfg_wdata};
                    vm_sp = vm_stack_top;
                    vm_fp = vm_stack_top;
                end
            end
            if (s_valid && s_ready) begin
                rd = 32'd0;
                case (item_cmd_e'(s_cmd))
                    CMD_WRITE: vm_mem[s_word_index] = s_write_value;
                    CMD_READ:  rd = vm_mem[s_word_index];
                    CMD_EXEC:  if (vm_status == RS_RUN) vm_status = vm_execute();
                    default: ;
                endcase
                exp_r = '{rd, vm_acc, vm_pc[16:0], vm_sp[16:0], vm_status,
                          (vm_status == RS_EXIT) ? vm_exit : 32'd0};
                expected_results.push_back(exp_r);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> tb/tb_stack_vm_instruction_step_unit.sv
// tb_stack_vm_instruction_step_unit: drives memory writes, reads and guarded random programs
// into the vm step unit under several idle patterns; svm_result_checker does the checking
// depends on svm_pkg, svm_result_checker and stack_vm_instruction_step_unit
module tb_stack_vm_instruction_step_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import svm_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [13:0] s_word_index = '0;
    logic signed [31:0] s_write_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_read_value, m_accumulator_out, m_exit_value;
    logic [16:0] m_program_counter_out, m_stack_pointer_out;
    logic [2:0]  m_run_status;

    int          mismatch_count, outstanding;
    logic [31:0] vm_pc, vm_sp, vm_fp, vm_acc;
    int          gap_pct = 0;
    int          stall_pct = 0;
    logic        stall_now = 1'b0;
    logic        stall_done = 1'b0;
    int          hold_left = 0;
    bit          on_edge = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    stack_vm_instruction_step_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_word_index(s_word_index), .s_write_value(s_write_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value),
        .m_accumulator_out(m_accumulator_out), .m_program_counter_out(m_program_counter_out),
        .m_stack_pointer_out(m_stack_pointer_out), .m_run_status(m_run_status),
        .m_exit_value(m_exit_value)
    );

    svm_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_word_index(s_word_index), .s_write_value(s_write_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value),
        .m_accumulator_out(m_accumulator_out), .m_program_counter_out(m_program_counter_out),
        .m_stack_pointer_out(m_stack_pointer_out), .m_run_status(m_run_status),
        .m_exit_value(m_exit_value),
        .mismatch_count(mismatch_count), .outstanding(outstanding),
        .vm_pc(vm_pc), .vm_sp(vm_sp), .vm_fp(vm_fp), .vm_acc(vm_acc)
    );

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (stall_now && !stall_done) begin
            hold_left <= 400;
            stall_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(0, 40);
            1: case ($urandom_range(4))
                   0: v = 32'd0;
                   1: v = 32'd1;
                   2: v = 32'h7FFF_FFFF;
                   3: v = 32'h8000_0000;
                   default: v = 32'hFFFF_FFFF;
               endcase
            2: v = $urandom_range(0, 16383) * 4;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(input item_cmd_e cmd, input int unsigned idx,
                             input logic [31:0] val);
        if (!on_edge) @(posedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_word_index <= idx[13:0];
        s_write_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        on_edge = 1'b1;
    endtask

    task automatic put_word(input logic [31:0] addr, input logic [31:0] val);
        send_item(CMD_WRITE, addr[15:2], val);
    endtask

    // settle after the last accepted item so the predicted state can be read
    task automatic sync_state();
        if (on_edge) s_valid <= 1'b0;
        @(negedge aclk);
        on_edge = 1'b0;
    endtask

    task automatic drain();
        if (on_edge) s_valid <= 1'b0;
        @(negedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
        repeat (60) @(posedge aclk);
        on_edge = 1'b1;
    endtask

    task automatic cfg_write(input cfg_idx_e idx, input logic [16:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic vm_step(input int want);
        int          pc, sp, fp, op, n, nset, k;
        logic [31:0] acc, imm, t;
        logic [31:0] set_addr [2];
        logic [31:0] set_val [2];
        bit          two, stuck;
        if (want < 0 && $urandom_range(9) < 2) begin
            case ($urandom_range(2))
                0: send_item(CMD_READ, $urandom_range(0, 255), $urandom);
                1: send_item(CMD_WRITE, $urandom_range(0, 16383), $urandom);
                default: send_item(CMD_NONE, $urandom_range(0, 16383), $urandom);
            endcase
        end
        sync_state();
        pc = vm_pc;
        sp = vm_sp;
        fp = vm_fp;
        acc = vm_acc;
        op = (want >= 0) ? want : $urandom_range(0, 29);
        if (pc > 65528) op = OP_LEV;
        imm = rand_word();
        nset = 0;
        stuck = 1'b0;
        case (op)
            OP_JMP, OP_CALL: begin
                imm = $urandom_range(0, 16383) * 4;
                if (op == OP_CALL && sp < 4) op = OP_IMM;
            end
            OP_JZ, OP_JNZ: begin
                if ((acc == 0) == (op == OP_JZ) || $urandom_range(1))
                    imm = $urandom_range(0, 16383) * 4;
                else
                    imm = $urandom;
            end
            OP_ENT: begin
                n = int'($urandom_range(0, 16)) - 8;
                if (sp < 4 || sp - 4 - 4 * n < 0 || sp - 4 - 4 * n > 65536) op = OP_IMM;
                else imm = n;
            end
            OP_ADJ: begin
                n = int'($urandom_range(0, 16)) - 8;
                if (sp + 4 * n < 0 || sp + 4 * n > 65536) n = 0;
                imm = n;
            end
            OP_LEV: begin
                if (fp > 65528 || fp % 4 != 0) begin
                    op = OP_IMM;
                end else begin
                    set_addr[0] = fp;
                    set_val[0] = ($urandom_range(3) == 0) ? 65536 : $urandom_range(0, 16383) * 4;
                    set_addr[1] = fp + 4;
                    set_val[1] = $urandom_range(0, 16383) * 4;
                    nset = 2;
                end
            end
            OP_LI: if (acc >= 1024 || acc[1:0] != 2'b00) begin
                op = OP_IMM;
                imm = $urandom_range(0, 255) * 4;
            end
            OP_LC: if (acc >= 1024) begin
                op = OP_IMM;
                imm = $urandom_range(0, 1023);
            end
            OP_SI, OP_SC: begin
                if (sp > 65532) begin
                    op = OP_IMM;
                end else begin
                    set_addr[0] = sp;
                    set_val[0] = (op == OP_SI) ? $urandom_range(0, 16383) * 4
                                               : $urandom_range(0, 1023);
                    nset = 1;
                end
            end
            OP_PUSH: if (sp < 4) op = OP_IMM;
            OP_LEA, OP_IMM: ;
            default: begin
                if (sp > 65532) begin
                    op = OP_IMM;
                end else begin
                    if ((op == OP_DIV || op == OP_MOD) && acc == 0) op = OP_SUB;
                    t = rand_word();
                    if (acc == 32'hFFFF_FFFF && $urandom_range(1)) t = 32'h8000_0000;
                    set_addr[0] = sp;
                    set_val[0] = t;
                    nset = 1;
                end
            end
        endcase
        two = (op <= OP_ADJ);
        if (two && pc > 65528) stuck = 1'b1;
        for (k = 0; k < nset; k++) begin
            if (set_addr[k][31:2] == pc / 4 || (two && set_addr[k][31:2] == pc / 4 + 1)) begin
                if (pc > 65528) begin
                    stuck = 1'b1;
                end else begin
                    op = OP_JMP;
                    imm = $urandom_range(0, 16383) * 4;
                    two = 1'b1;
                    nset = 0;
                end
            end
        end
        if (stuck) begin
            drain();
            cfg_write(CFG_START_ADDR, 17'($urandom_range(0, 16380) * 4));
        end else begin
            for (k = 0; k < nset; k++) put_word(set_addr[k], set_val[k]);
            put_word(pc, op);
            if (two) put_word(pc + 4, imm);
            send_item(CMD_EXEC, $urandom_range(0, 16383), $urandom);
        end
    endtask

    task automatic halt_machine();
        int pc, sp;
        sync_state();
        pc = vm_pc;
        sp = vm_sp;
        if (sp <= 65532 && sp / 4 != pc / 4 && $urandom_range(2) != 0) begin
            put_word(sp, rand_word());
            put_word(pc, OP_EXIT);
        end else if ($urandom_range(1)) begin
            put_word(pc, $urandom_range(30, 36));
        end else begin
            put_word(pc, 32'h8000_0000 | $urandom);
        end
        send_item(CMD_EXEC, 0, 0);
        send_item(CMD_EXEC, 16383, 32'hFFFF_FFFF);
        send_item(CMD_READ, pc / 4, 0);
        send_item(CMD_NONE, 0, 0);
    endtask

    initial begin
        int i, ph;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        on_edge = 1'b1;
        // data window read by loads, byte stores and random reads
        for (i = 0; i < 256; i++) send_item(CMD_WRITE, i, 32'd0);
        send_item(CMD_WRITE, 16383, 32'h8000_0000);
        send_item(CMD_WRITE, 0, 32'h7FFF_FFFF);
        send_item(CMD_READ, 16383, 32'hFFFF_FFFF);
        send_item(CMD_READ, 0, 0);
        send_item(CMD_WRITE, 16383, 32'hFFFF_FFFF);
        send_item(CMD_READ, 16383, 0);
        send_item(CMD_NONE, 16383, 32'hFFFF_FFFF);
        for (i = 0; i <= 29; i++) vm_step(i);
        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    gap_pct = 0;  stall_pct = 0;
                    cfg_write(CFG_START_ADDR, 17'd0);
                    cfg_write(CFG_STACK_TOP, 17'd65536);
                end
                1: begin
                    gap_pct = 71; stall_pct = 0;
                    cfg_write(CFG_START_ADDR, 17'd65532);
                    cfg_write(CFG_STACK_TOP, 17'd0);
                end
                2: begin
                    gap_pct = 0;  stall_pct = 71;
                    cfg_write(CFG_START_ADDR, 17'($urandom_range(0, 16380) * 4));
                    cfg_write(CFG_STACK_TOP, 17'($urandom_range(0, 16384) * 4));
                end
                default: begin
                    gap_pct = 30; stall_pct = 30;
                    cfg_write(CFG_START_ADDR, 17'($urandom_range(0, 16380) * 4));
                    cfg_write(CFG_STACK_TOP, 17'd65536);
                end
            endcase
            for (i = 0; i < 30; i++) begin
                vm_step(-1);
                if (ph == 0 && i == 20) stall_now <= 1'b1;
            end
        end
        halt_machine();
        drain();
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
rtl/svm_pkg.sv
rtl/svm_div.sv
rtl/svm_dp.sv
rtl/svm_ctrl.sv
rtl/stack_vm_instruction_step_unit.sv
rtl/svm_chk.sv
tb/svm_result_checker.sv
tb/tb_stack_vm_instruction_step_unit.sv
